>>> hw/rtl/vertex_model_transform_assert.svh
// Assertion macros for the vertex transform checker.
// Both use the checker's clk and arst_n.
`ifndef VERTEX_MODEL_TRANSFORM_ASSERT_SVH
`define VERTEX_MODEL_TRANSFORM_ASSERT_SVH

// same-cycle implication
`define VMT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VMT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/vmt_pkg.sv
package vmt_pkg;

	localparam int NUM_REGS = 8;
	localparam int IDX_W    = 4;
	localparam int DIV_W    = 36;
	localparam int DEN_W    = 9;

	localparam logic [IDX_W-1:0] REG_OFFSET_X = 4'd0;
	localparam logic [IDX_W-1:0] REG_OFFSET_Y = 4'd1;
	localparam logic [IDX_W-1:0] REG_OFFSET_Z = 4'd2;
	localparam logic [IDX_W-1:0] REG_YAW      = 4'd3;
	localparam logic [IDX_W-1:0] REG_PITCH    = 4'd4;
	localparam logic [IDX_W-1:0] REG_SCALE_X  = 4'd5;
	localparam logic [IDX_W-1:0] REG_SCALE_Y  = 4'd6;
	localparam logic [IDX_W-1:0] REG_SCALE_Z  = 4'd7;

	typedef enum logic [3:0] {
		BS_IDLE,
		BS_REDUCE,
		BS_SQ,
		BS_SQ_W,
		BS_TERM,
		BS_TERM_W,
		BS_DIV,
		BS_SIN,
		BS_SIN_W,
		BS_STORE,
		BS_MAT,
		BS_MAT_W
	} bld_state_t;

	// linear terms Q22, translation in coordinate format; row 2 col 0 is zero
	typedef struct packed {
		logic signed [31:0] m00;
		logic signed [31:0] m01;
		logic signed [31:0] m02;
		logic signed [31:0] m10;
		logic signed [31:0] m11;
		logic signed [31:0] m12;
		logic signed [31:0] m21;
		logic signed [31:0] m22;
		logic signed [31:0] t0;
		logic signed [31:0] t1;
		logic signed [31:0] t2;
	} mat_t;

	typedef struct packed {
		logic                    start;
		logic signed [DIV_W-1:0] num;
		logic [DEN_W-1:0]        den;
	} div_req_t;

	typedef struct packed {
		logic                    busy;
		logic signed [DIV_W-1:0] quo;
	} div_rsp_t;

endpackage

>>> hw/rtl/vmt_div.sv
module vmt_div (
	input  logic              clk,
	input  logic              arst_n,
	input  vmt_pkg::div_req_t req,
	output vmt_pkg::div_rsp_t rsp
);
	import vmt_pkg::*;

	localparam int          RCP_SH = 40;
	localparam logic [63:0] P40    = 64'd1 << RCP_SH;

	// floor(n / d) for 0 <= n < 2^32 and a series divisor d <= 240:
	// n * ceil(2^40 / d) >> 40, reciprocal taken in two 20-bit halves
	logic        busy_q;
	logic        ph_q;
	logic [31:0] n_q;
	logic [39:0] rcp_q;
	logic [51:0] lo_q;
	logic [31:0] quo_q;
	logic [39:0] rcp;
	logic [19:0] rcp_half;
	logic [51:0] prod;
	logic [72:0] acc;

	always_comb begin
		case (req.den)
			9'd2:    rcp = 40'((P40 + 64'd1) / 64'd2);
			9'd6:    rcp = 40'((P40 + 64'd5) / 64'd6);
			9'd12:   rcp = 40'((P40 + 64'd11) / 64'd12);
			9'd20:   rcp = 40'((P40 + 64'd19) / 64'd20);
			9'd30:   rcp = 40'((P40 + 64'd29) / 64'd30);
			9'd42:   rcp = 40'((P40 + 64'd41) / 64'd42);
			9'd56:   rcp = 40'((P40 + 64'd55) / 64'd56);
			9'd72:   rcp = 40'((P40 + 64'd71) / 64'd72);
			9'd90:   rcp = 40'((P40 + 64'd89) / 64'd90);
			9'd110:  rcp = 40'((P40 + 64'd109) / 64'd110);
			9'd132:  rcp = 40'((P40 + 64'd131) / 64'd132);
			9'd156:  rcp = 40'((P40 + 64'd155) / 64'd156);
			9'd182:  rcp = 40'((P40 + 64'd181) / 64'd182);
			9'd210:  rcp = 40'((P40 + 64'd209) / 64'd210);
			9'd240:  rcp = 40'((P40 + 64'd239) / 64'd240);
			default: rcp = '0;
		endcase
	end

	assign rcp_half = ph_q ? rcp_q[39:20] : rcp_q[19:0];
	assign prod     = 52'(n_q) * 52'(rcp_half);
	assign acc      = {1'b0, prod, 20'd0} + 73'(lo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			ph_q   <= 1'b0;
		end else if (busy_q) begin
			ph_q <= !ph_q;
			if (ph_q)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q   <= req.num[31:0];
			rcp_q <= rcp;
		end else if (busy_q) begin
			if (!ph_q)
				lo_q <= prod;
			else
				quo_q <= acc[71:40];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.quo  = $signed({{(DIV_W-32){1'b0}}, quo_q});

endmodule

>>> hw/rtl/vmt_builder.sv
module vmt_builder (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic [vmt_pkg::IDX_W-1:0] cfg_index,
	input  logic [31:0]               cfg_data,
	output logic                      busy,
	output vmt_pkg::mat_t             mat
);
	import vmt_pkg::*;

	localparam logic signed [35:0] PI36      = 36'sd3373259426;
	localparam logic signed [35:0] NEG_PI36  = -36'sd3373259426;
	localparam logic signed [35:0] HPI36     = 36'sd1686629713;
	localparam logic signed [35:0] NEG_HPI36 = -36'sd1686629713;
	localparam logic signed [35:0] TWO_PI36  = 36'sd6746518852;
	localparam logic signed [35:0] ONE36     = 36'sd1073741824;
	localparam logic signed [32:0] ONE33     = 33'sd1073741824;
	localparam logic signed [65:0] RND30     = 66'sd536870912;
	localparam logic signed [65:0] RND24     = 66'sd8388608;
	localparam logic signed [31:0] ID22      = 32'sd4194304;
	localparam logic [3:0]         LAST_J    = 4'd11;

	function automatic logic [DEN_W-1:0] series_div(input logic cos_sel, input logic [3:0] k);
		logic [DEN_W-1:0] k2;
		k2 = {4'd0, k, 1'b0};
		if (cos_sel)
			return DEN_W'((k2 - 9'd1) * k2);
		return DEN_W'(k2 * (k2 + 9'd1));
	endfunction

	bld_state_t state_q, state_d;

	logic [31:0]        off_x_q, off_y_q, off_z_q;
	logic [19:0]        yaw_q, pitch_q;
	logic [23:0]        scx_q, scy_q, scz_q;
	logic signed [31:0] m00_q, m01_q, m02_q, m10_q, m11_q, m12_q, m21_q, m22_q;

	logic               ang_q, cos_sel_q, neg_q;
	logic [3:0]         k_q, j_q;
	logic signed [32:0] a_q, x2_q, t_q;
	logic signed [32:0] sy_q, cy_q, sp_q, cp_q;
	logic signed [32:0] psycp_q, psysp_q, pcycp_q, pcysp_q;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_q;

	logic               cfg_we, idx_ok;
	logic signed [35:0] ang_w, red;
	logic               fold;
	logic signed [65:0] r30_full, r24_full, n2;
	logic signed [32:0] r30;
	logic signed [31:0] r24;
	logic signed [35:0] t_next;
	logic signed [32:0] scx_w, scy_w, scz_w;
	logic [DEN_W-1:0]   den;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	assign busy   = (state_q != BS_IDLE);
	assign cfg_we = cfg_valid && !busy;
	assign idx_ok = (cfg_index < IDX_W'(NUM_REGS));

	assign scx_w = {{9{scx_q[23]}}, scx_q};
	assign scy_w = {{9{scy_q[23]}}, scy_q};
	assign scz_w = {{9{scz_q[23]}}, scz_q};

	// angle to Q30, one wrap by 2*pi, fold into [-pi/2, pi/2]
	always_comb begin
		ang_w = ang_q ? {{2{pitch_q[19]}}, pitch_q, 14'd0} : {{2{yaw_q[19]}}, yaw_q, 14'd0};
		red   = ang_w;
		fold  = 1'b0;
		if (red > PI36)
			red = red - TWO_PI36;
		if (red < NEG_PI36)
			red = red + TWO_PI36;
		if (red > HPI36) begin
			red  = PI36 - red;
			fold = 1'b1;
		end else if (red < NEG_HPI36) begin
			red  = NEG_PI36 - red;
			fold = 1'b1;
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			BS_SQ: begin
				mul_a = a_q;
				mul_b = a_q;
			end
			BS_TERM: begin
				mul_a = x2_q;
				mul_b = t_q;
			end
			BS_SIN: begin
				mul_a = a_q;
				mul_b = t_q;
			end
			BS_MAT: begin
				case (j_q)
					4'd0: begin mul_a = sy_q; mul_b = cp_q; end
					4'd1: begin mul_a = sy_q; mul_b = sp_q; end
					4'd2: begin mul_a = cy_q; mul_b = cp_q; end
					4'd3: begin mul_a = cy_q; mul_b = sp_q; end
					4'd4: begin mul_a = cy_q; mul_b = scx_w; end
					4'd5: begin mul_a = -psycp_q; mul_b = scy_w; end
					4'd6: begin mul_a = psysp_q; mul_b = scz_w; end
					4'd7: begin mul_a = sy_q; mul_b = scx_w; end
					4'd8: begin mul_a = pcycp_q; mul_b = scy_w; end
					4'd9: begin mul_a = -pcysp_q; mul_b = scz_w; end
					4'd10: begin mul_a = sp_q; mul_b = scy_w; end
					4'd11: begin mul_a = cp_q; mul_b = scz_w; end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	assign r30_full = (mul_q + RND30) >>> 30;
	assign r24_full = (mul_q + RND24) >>> 24;
	assign r30      = r30_full[32:0];
	assign r24      = r24_full[31:0];

	// rd(x2*t, 2^30*m) == floor(floor((x2*t + 2^29*m) / 2^30) / m)
	assign den = series_div(cos_sel_q, k_q);
	assign n2  = mul_q + $signed({28'd0, den, 29'd0});

	assign div_req.start = (state_q == BS_TERM_W);
	assign div_req.num   = n2[65:30];
	assign div_req.den   = den;

	vmt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign t_next = ONE36 - div_rsp.quo;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BS_IDLE:   if (cfg_we && idx_ok) state_d = BS_REDUCE;
			BS_REDUCE: state_d = BS_SQ;
			BS_SQ:     state_d = BS_SQ_W;
			BS_SQ_W:   state_d = BS_TERM;
			BS_TERM:   state_d = BS_TERM_W;
			BS_TERM_W: state_d = BS_DIV;
			BS_DIV: begin
				if (!div_rsp.busy) begin
					if (k_q == 4'd1)
						state_d = cos_sel_q ? BS_STORE : BS_SIN;
					else
						state_d = BS_TERM;
				end
			end
			BS_SIN:    state_d = BS_SIN_W;
			BS_SIN_W:  state_d = BS_TERM;
			BS_STORE:  state_d = ang_q ? BS_MAT : BS_REDUCE;
			BS_MAT:    state_d = BS_MAT_W;
			BS_MAT_W:  state_d = (j_q == LAST_J) ? BS_IDLE : BS_MAT;
			default:   state_d = BS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BS_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0;
			off_y_q <= '0;
			off_z_q <= '0;
			yaw_q   <= '0;
			pitch_q <= '0;
			scx_q   <= 24'd65536;
			scy_q   <= 24'd65536;
			scz_q   <= 24'd65536;
			m00_q   <= ID22;
			m01_q   <= '0;
			m02_q   <= '0;
			m10_q   <= '0;
			m11_q   <= ID22;
			m12_q   <= '0;
			m21_q   <= '0;
			m22_q   <= ID22;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_OFFSET_X: off_x_q <= cfg_data;
					REG_OFFSET_Y: off_y_q <= cfg_data;
					REG_OFFSET_Z: off_z_q <= cfg_data;
					REG_YAW:      yaw_q   <= cfg_data[19:0];
					REG_PITCH:    pitch_q <= cfg_data[19:0];
					REG_SCALE_X:  scx_q   <= cfg_data[23:0];
					REG_SCALE_Y:  scy_q   <= cfg_data[23:0];
					REG_SCALE_Z:  scz_q   <= cfg_data[23:0];
					default: ;
				endcase
			end
			if (state_q == BS_MAT_W) begin
				case (j_q)
					4'd4:  m00_q <= r24;
					4'd5:  m01_q <= r24;
					4'd6:  m02_q <= r24;
					4'd7:  m10_q <= r24;
					4'd8:  m11_q <= r24;
					4'd9:  m12_q <= r24;
					4'd10: m21_q <= r24;
					4'd11: m22_q <= r24;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BS_IDLE: ang_q <= 1'b0;
			BS_REDUCE: begin
				a_q   <= red[32:0];
				neg_q <= fold;
			end
			BS_SQ_W: begin
				x2_q      <= r30;
				t_q       <= ONE33;
				cos_sel_q <= 1'b0;
				k_q       <= 4'd7;
			end
			BS_DIV: begin
				if (!div_rsp.busy) begin
					t_q <= t_next[32:0];
					k_q <= k_q - 4'd1;
				end
			end
			BS_SIN_W: begin
				if (ang_q)
					sp_q <= r30;
				else
					sy_q <= r30;
				t_q       <= ONE33;
				cos_sel_q <= 1'b1;
				k_q       <= 4'd8;
			end
			BS_STORE: begin
				if (ang_q)
					cp_q <= neg_q ? -t_q : t_q;
				else
					cy_q <= neg_q ? -t_q : t_q;
				ang_q <= 1'b1;
				j_q   <= '0;
			end
			BS_MAT_W: begin
				case (j_q)
					4'd0: psycp_q <= r30;
					4'd1: psysp_q <= r30;
					4'd2: pcycp_q <= r30;
					4'd3: pcysp_q <= r30;
					default: ;
				endcase
				j_q <= j_q + 4'd1;
			end
			default: ;
		endcase
	end

	always_comb begin
		mat.m00 = m00_q;
		mat.m01 = m01_q;
		mat.m02 = m02_q;
		mat.m10 = m10_q;
		mat.m11 = m11_q;
		mat.m12 = m12_q;
		mat.m21 = m21_q;
		mat.m22 = m22_q;
		mat.t0  = off_x_q;
		mat.t1  = off_y_q;
		mat.t2  = off_z_q;
	end

endmodule

>>> hw/rtl/vmt_datapath.sv
module vmt_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  vmt_pkg::mat_t      mat,
	input  logic               busy,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic signed [31:0] normal_x,
	input  logic signed [31:0] normal_y,
	input  logic signed [31:0] normal_z,
	input  logic signed [15:0] tex_u,
	input  logic signed [15:0] tex_v,
	input  logic signed [15:0] tex_layer,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_point_x,
	output logic signed [31:0] out_point_y,
	output logic signed [31:0] out_point_z,
	output logic signed [31:0] out_normal_x,
	output logic signed [31:0] out_normal_y,
	output logic signed [31:0] out_normal_z,
	output logic signed [15:0] out_tex_u,
	output logic signed [15:0] out_tex_v,
	output logic signed [15:0] out_tex_layer
);
	import vmt_pkg::*;

	localparam logic signed [66:0] RND22   = 67'sd2097152;
	localparam logic signed [66:0] SAT_MAX = 67'sd2147483647;
	localparam logic signed [66:0] SAT_MIN = -67'sd2147483648;

	function automatic logic [31:0] rnd_sat(input logic signed [66:0] s);
		logic signed [66:0] r;
		r = (s + RND22) >>> 22;
		if (r > SAT_MAX)
			return 32'h7fffffff;
		if (r < SAT_MIN)
			return 32'h80000000;
		return r[31:0];
	endfunction

	logic               adv, accept;
	logic signed [31:0] mlin [3][3];
	logic signed [31:0] tr [3];
	logic signed [31:0] pin [3];
	logic signed [31:0] nin [3];

	logic               v_s1, v_s2, v_s3;
	logic signed [63:0] pp_s1 [3][3];
	logic signed [63:0] pn_s1 [3][3];
	logic signed [31:0] tr_s1 [3];
	logic signed [15:0] tu_s1, tv_s1, tl_s1;
	logic signed [66:0] sp_s2 [3];
	logic signed [66:0] sn_s2 [3];
	logic signed [15:0] tu_s2, tv_s2, tl_s2;
	logic signed [31:0] op_s3 [3];
	logic signed [31:0] on_s3 [3];
	logic signed [15:0] tu_s3, tv_s3, tl_s3;

	assign adv      = !(v_s3 && out_stall);
	assign in_stall = !adv || busy;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		mlin[0][0] = mat.m00;
		mlin[0][1] = mat.m01;
		mlin[0][2] = mat.m02;
		mlin[1][0] = mat.m10;
		mlin[1][1] = mat.m11;
		mlin[1][2] = mat.m12;
		mlin[2][0] = '0;
		mlin[2][1] = mat.m21;
		mlin[2][2] = mat.m22;
		tr[0]      = mat.t0;
		tr[1]      = mat.t1;
		tr[2]      = mat.t2;
		pin[0]     = point_x;
		pin[1]     = point_y;
		pin[2]     = point_z;
		nin[0]     = normal_x;
		nin[1]     = normal_y;
		nin[2]     = normal_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// s1: products, s2: row sums, s3: round and saturate
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pp_s1[i][j] <= 64'(mlin[i][j]) * 64'(pin[j]);
					pn_s1[i][j] <= 64'(mlin[i][j]) * 64'(nin[j]);
				end
				tr_s1[i] <= tr[i];
			end
			tu_s1 <= tex_u;
			tv_s1 <= tex_v;
			tl_s1 <= tex_layer;

			for (int i = 0; i < 3; i++) begin
				sn_s2[i] <= 67'(pn_s1[i][0]) + 67'(pn_s1[i][1]) + 67'(pn_s1[i][2]);
				sp_s2[i] <= 67'(pp_s1[i][0]) + 67'(pp_s1[i][1]) + 67'(pp_s1[i][2])
					+ (67'(tr_s1[i]) <<< 22);
			end
			tu_s2 <= tu_s1;
			tv_s2 <= tv_s1;
			tl_s2 <= tl_s1;

			for (int i = 0; i < 3; i++) begin
				op_s3[i] <= rnd_sat(sp_s2[i]);
				on_s3[i] <= rnd_sat(sn_s2[i]);
			end
			tu_s3 <= tu_s2;
			tv_s3 <= tv_s2;
			tl_s3 <= tl_s2;
		end
	end

	assign out_valid     = v_s3;
	assign out_point_x   = op_s3[0];
	assign out_point_y   = op_s3[1];
	assign out_point_z   = op_s3[2];
	assign out_normal_x  = on_s3[0];
	assign out_normal_y  = on_s3[1];
	assign out_normal_z  = on_s3[2];
	assign out_tex_u     = tu_s3;
	assign out_tex_v     = tv_s3;
	assign out_tex_layer = tl_s3;

endmodule

>>> hw/rtl/vertex_model_transform.sv
// Vertex model transform: one vertex (position, normal, texture triple) per word
// on the input channel, one transformed vertex per word on the output channel.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// Position gets M * (p, 1), normal gets M * (n, 0), both rounded and saturated;
// the texture triple is copied.
// Throughput: one word per cycle while neither out_stall nor a rebuild holds
// the flow, set by the three-stage multiply/sum/round pipeline. An accepted
// word passes the registers s1, s2 and s3 before out_valid shows it.
// A word held by out_stall holds all stages; input stall follows at once.
// Config: valid/ready write port, index 0..7 as offsets, yaw, pitch, scales.
// Indices 8..15 are accepted and ignored. Each write to a real register
// rebuilds the matrix with a shared multiplier and a reciprocal multiply for
// the sine/cosine series divisions, with cfg_ready low and in_stall high.
// Reset: pipeline empty, registers at offset 0, angles 0, scale 1.0, matrix
// identity; the block is ready right after reset.
module vertex_model_transform (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic signed [31:0] normal_x,
	input  logic signed [31:0] normal_y,
	input  logic signed [31:0] normal_z,
	input  logic signed [15:0] tex_u,
	input  logic signed [15:0] tex_v,
	input  logic signed [15:0] tex_layer,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_point_x,
	output logic signed [31:0] out_point_y,
	output logic signed [31:0] out_point_z,
	output logic signed [31:0] out_normal_x,
	output logic signed [31:0] out_normal_y,
	output logic signed [31:0] out_normal_z,
	output logic signed [15:0] out_tex_u,
	output logic signed [15:0] out_tex_v,
	output logic signed [15:0] out_tex_layer,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import vmt_pkg::*;

	mat_t mat;
	logic bld_busy;

	assign cfg_ready = !bld_busy;

	vmt_builder u_builder (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (bld_busy),
		.mat       (mat)
	);

	vmt_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.mat           (mat),
		.busy          (bld_busy),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.point_x       (point_x),
		.point_y       (point_y),
		.point_z       (point_z),
		.normal_x      (normal_x),
		.normal_y      (normal_y),
		.normal_z      (normal_z),
		.tex_u         (tex_u),
		.tex_v         (tex_v),
		.tex_layer     (tex_layer),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_point_x   (out_point_x),
		.out_point_y   (out_point_y),
		.out_point_z   (out_point_z),
		.out_normal_x  (out_normal_x),
		.out_normal_y  (out_normal_y),
		.out_normal_z  (out_normal_z),
		.out_tex_u     (out_tex_u),
		.out_tex_v     (out_tex_v),
		.out_tex_layer (out_tex_layer)
	);

endmodule

>>> hw/rtl/vmt_checker.sv
`include "vertex_model_transform_assert.svh"

module vmt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [15:0] tex_u,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] out_tex_u,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [3:0]  cfg_index
);
	import vmt_pkg::*;

	`VMT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "output word dropped under stall")

	`VMT_ASSERT_NOW(a_busy_stall, !cfg_ready, in_stall, "input taken during matrix rebuild")

	`VMT_ASSERT_NEXT(a_cfg_rebuild, cfg_valid && cfg_ready && (cfg_index < IDX_W'(NUM_REGS)), in_stall && !cfg_ready, "no rebuild after register write")

	`VMT_ASSERT_NEXT(a_latency, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall, out_valid && (out_tex_u == $past(tex_u, 3)), "word not out after three cycles")

endmodule

bind vertex_model_transform vmt_checker u_vmt_checker (.*);

>>> bench/vertex_model_transform_tb.sv
`timescale 1ns / 1ps

module vertex_model_transform_tb;
	import vmt_pkg::*;

	typedef struct {
		logic signed [31:0] pt[3];
		logic signed [31:0] nm[3];
		logic signed [15:0] tx[3];
	} vertex_t;

	class vertex_scoreboard;
		logic [31:0] cfg[NUM_REGS];
		longint mat[12];
		vertex_t expected_q[$];
		int errors;
		int checked;

		function new();
			reset();
		endfunction

		function void reset();
			foreach (cfg[i]) cfg[i] = 0;
			cfg[REG_SCALE_X] = 65536;
			cfg[REG_SCALE_Y] = 65536;
			cfg[REG_SCALE_Z] = 65536;
			rebuild();
		endfunction

		function longint rnd_div(longint n, longint d);
			longint n2;
			n2 = n + d / 2;
			if (n2 >= 0) return n2 / d;
			return -((-n2 + d - 1) / d);
		endfunction

		function longint sat32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function void sin_cos(longint ang, output longint s, output longint c);
			longint one, pi, half_pi, a, x2, t;
			bit flip;
			one = 64'sd1073741824;
			pi = 64'sd3373259426;
			half_pi = 64'sd1686629713;
			a = ang * 16384;
			flip = 0;
			if (a > pi) a -= 2 * pi;
			if (a < -pi) a += 2 * pi;
			if (a > half_pi) begin
				a = pi - a;
				flip = 1;
			end else if (a < -half_pi) begin
				a = -pi - a;
				flip = 1;
			end
			x2 = rnd_div(a * a, one);
			t = one;
			for (int k = 7; k >= 1; k--)
				t = one - rnd_div(x2 * t, one * longint'((2 * k) * (2 * k + 1)));
			s = rnd_div(a * t, one);
			t = one;
			for (int k = 8; k >= 1; k--)
				t = one - rnd_div(x2 * t, one * longint'((2 * k - 1) * (2 * k)));
			c = flip ? -t : t;
		endfunction

		function longint lin(longint trig, longint sc);
			return rnd_div(trig * sc, 64'sd16777216);
		endfunction

		function void rebuild();
			longint sy, cy, sp, cp, sx, sy2, sz, one;
			one = 64'sd1073741824;
			sx = longint'($signed(cfg[REG_SCALE_X][23:0]));
			sy2 = longint'($signed(cfg[REG_SCALE_Y][23:0]));
			sz = longint'($signed(cfg[REG_SCALE_Z][23:0]));
			sin_cos(longint'($signed(cfg[REG_YAW][19:0])), sy, cy);
			sin_cos(longint'($signed(cfg[REG_PITCH][19:0])), sp, cp);
			mat[0] = lin(cy, sx);
			mat[1] = lin(-rnd_div(sy * cp, one), sy2);
			mat[2] = lin(rnd_div(sy * sp, one), sz);
			mat[3] = longint'($signed(cfg[REG_OFFSET_X]));
			mat[4] = lin(sy, sx);
			mat[5] = lin(rnd_div(cy * cp, one), sy2);
			mat[6] = lin(-rnd_div(cy * sp, one), sz);
			mat[7] = longint'($signed(cfg[REG_OFFSET_Y]));
			mat[8] = 0;
			mat[9] = lin(sp, sy2);
			mat[10] = lin(cp, sz);
			mat[11] = longint'($signed(cfg[REG_OFFSET_Z]));
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				REG_OFFSET_X, REG_OFFSET_Y, REG_OFFSET_Z: cfg[idx] = data;
				REG_YAW, REG_PITCH: cfg[idx] = {12'd0, data[19:0]};
				REG_SCALE_X, REG_SCALE_Y, REG_SCALE_Z: cfg[idx] = {8'd0, data[23:0]};
				default: return;
			endcase
			rebuild();
		endfunction

		function void note_vertex(vertex_t v);
			vertex_t e;
			longint ap, an;
			for (int i = 0; i < 3; i++) begin
				ap = mat[4*i] * v.pt[0] + mat[4*i+1] * v.pt[1] + mat[4*i+2] * v.pt[2]
					+ mat[4*i+3] * 64'sd4194304;
				an = mat[4*i] * v.nm[0] + mat[4*i+1] * v.nm[1] + mat[4*i+2] * v.nm[2];
				e.pt[i] = 32'(sat32(rnd_div(ap, 64'sd4194304)));
				e.nm[i] = 32'(sat32(rnd_div(an, 64'sd4194304)));
				e.tx[i] = v.tx[i];
			end
			expected_q = {expected_q, e};
		endfunction

		function void cmp(string name, longint e, longint a);
			if (e != a) begin
				errors++;
				$error("%s: expected %0d, got %0d", name, e, a);
			end
		endfunction

		function void check_vertex(vertex_t r);
			vertex_t e;
			string ax[3];
			ax = '{"x", "y", "z"};
			if (expected_q.size() == 0) begin
				errors++;
				$error("output word with nothing outstanding");
				return;
			end
			e = expected_q.pop_front();
			checked++;
			for (int i = 0; i < 3; i++) begin
				cmp({"out_point_", ax[i]}, e.pt[i], r.pt[i]);
				cmp({"out_normal_", ax[i]}, e.nm[i], r.nm[i]);
			end
			cmp("out_tex_u", e.tx[0], r.tx[0]);
			cmp("out_tex_v", e.tx[1], r.tx[1]);
			cmp("out_tex_layer", e.tx[2], r.tx[2]);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_stall;
	logic signed [31:0] point_x = 0, point_y = 0, point_z = 0;
	logic signed [31:0] normal_x = 0, normal_y = 0, normal_z = 0;
	logic signed [15:0] tex_u = 0, tex_v = 0, tex_layer = 0;
	logic out_valid, out_stall = 0;
	logic signed [31:0] out_point_x, out_point_y, out_point_z;
	logic signed [31:0] out_normal_x, out_normal_y, out_normal_z;
	logic signed [15:0] out_tex_u, out_tex_v, out_tex_layer;
	logic cfg_valid = 0, cfg_ready;
	logic [3:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;

	vertex_scoreboard sb = new();
	int tx_max = 18;
	int rx_max = 18;
	bit hold_req = 0;
	int sent = 0;
	int cfg_writes = 0;

	vertex_model_transform uut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		vertex_t v, r;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				v.pt = '{point_x, point_y, point_z};
				v.nm = '{normal_x, normal_y, normal_z};
				v.tx = '{tex_u, tex_v, tex_layer};
				sb.note_vertex(v);
			end
			if (out_valid && !out_stall) begin
				r.pt = '{out_point_x, out_point_y, out_point_z};
				r.nm = '{out_normal_x, out_normal_y, out_normal_z};
				r.tx = '{out_tex_u, out_tex_v, out_tex_layer};
				sb.check_vertex(r);
			end
		end
	end

	// receiver: random stall per word, plus one long hold when hold_req is set
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1;
				repeat (400) @(negedge clk);
				hold_req = 0;
				out_stall <= 0;
			end else begin
				n = rx_max > 0 ? $urandom_range(0, rx_max) : 0;
				if (n > 0) begin
					out_stall <= 1;
					repeat (n) @(negedge clk);
					out_stall <= 0;
				end
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		#20ms;
		$display("vertex_model_transform_tb: done, errors");
		$finish;
	end

	// call at a falling edge; returns at the falling edge after acceptance
	task automatic send_vertex(vertex_t v);
		int g;
		g = tx_max > 0 ? $urandom_range(0, tx_max) : 0;
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
		{point_x, point_y, point_z} <= {v.pt[0], v.pt[1], v.pt[2]};
		{normal_x, normal_y, normal_z} <= {v.nm[0], v.nm[1], v.nm[2]};
		{tex_u, tex_v, tex_layer} <= {v.tx[0], v.tx[1], v.tx[2]};
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 0;
		while (sb.pending() > 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_cfg(logic [3:0] idx, logic [31:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] rnd_coord();
		logic [31:0] ext[5];
		ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff};
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2: return $urandom_range(0, 1 << 21) - (1 << 20);
			3: return ext[$urandom_range(0, 4)];
			default: return $urandom_range(0, 1 << 25) - (1 << 24);
		endcase
	endfunction

	function automatic vertex_t rnd_vertex();
		vertex_t v;
		for (int i = 0; i < 3; i++) begin
			v.pt[i] = rnd_coord();
			v.nm[i] = rnd_coord();
			v.tx[i] = 16'($urandom);
		end
		return v;
	endfunction

	function automatic vertex_t flat_vertex(logic [31:0] c, logic [15:0] t);
		vertex_t v;
		v.pt = '{c, c, c};
		v.nm = '{c, c, c};
		v.tx = '{t, t, t};
		return v;
	endfunction

	task automatic write_rnd_cfg();
		logic [31:0] d;
		logic [31:0] ang_ext[5], sc_ext[5];
		ang_ext = '{32'd411775, -32'sd411775, 32'd102944, 32'd205887, 32'd0};
		sc_ext = '{32'h80_0000, 32'h7f_ffff, 32'd0, 32'd65536, -32'sd65536};
		for (int i = 0; i < NUM_REGS; i++) begin
			if ($urandom_range(0, 2) == 0) continue;
			if (i <= REG_OFFSET_Z)
				d = rnd_coord();
			else if (i <= REG_PITCH)
				d = $urandom_range(0, 3) == 0 ? ang_ext[$urandom_range(0, 4)]
					: $urandom_range(0, 823550) - 411775;
			else
				case ($urandom_range(0, 3))
					0: d = sc_ext[$urandom_range(0, 4)];
					1: d = $urandom_range(0, 16777215) - 8388608;
					default: d = $urandom_range(0, 1 << 18) - (1 << 17);
				endcase
			write_cfg(4'(i), d);
		end
		if ($urandom_range(0, 4) == 0)
			write_cfg(4'($urandom_range(8, 15)), $urandom);
	endtask

	initial begin
		logic [31:0] ext[5];
		logic [15:0] text[5];
		ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff};
		text = '{16'h8000, 16'h7fff, 16'h0, 16'h1, 16'hffff};
		repeat (11) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// identity matrix out of reset
		for (int i = 0; i < 5; i++) send_vertex(flat_vertex(ext[i], text[i]));
		for (int i = 0; i < 3; i++) send_vertex(rnd_vertex());
		wait_idle();

		// extreme settings
		for (int s = 0; s < 3; s++) begin
			case (s)
				0: begin
					for (int i = 0; i < 3; i++) write_cfg(4'(i), 32'h7fff_ffff);
					write_cfg(REG_YAW, 32'd411775);
					write_cfg(REG_PITCH, -32'sd411775);
					for (int i = 5; i < 8; i++) write_cfg(4'(i), 32'h7f_ffff);
				end
				1: begin
					for (int i = 0; i < 3; i++) write_cfg(4'(i), 32'h8000_0000);
					write_cfg(REG_YAW, -32'sd411775);
					write_cfg(REG_PITCH, 32'd411775);
					for (int i = 5; i < 8; i++) write_cfg(4'(i), 32'h80_0000);
				end
				default: begin
					write_cfg(REG_YAW, 32'd102944);
					write_cfg(REG_PITCH, 32'd205887);
					for (int i = 5; i < 8; i++) write_cfg(4'(i), 32'd0);
					write_cfg(4'd9, 32'hdead_beef);
				end
			endcase
			for (int i = 0; i < 5; i++) send_vertex(flat_vertex(ext[i], text[i]));
			wait_idle();
		end

		// random phases
		for (int ph = 0; ph < 12; ph++) begin
			write_rnd_cfg();
			tx_max = (ph % 4 == 1) ? 0 : 18;
			rx_max = (ph % 4 == 2) ? 0 : 18;
			if (ph == 5) begin
				tx_max = 0;
				hold_req = 1;
			end
			for (int i = 0; i < 150; i++) send_vertex(rnd_vertex());
			wait_idle();
		end

		wait_idle();
		repeat (20) @(negedge clk);
		$display("covered %0d vertices over %0d register writes, %0d words checked",
			sent, cfg_writes, sb.checked);
		$display("settings included angle and scale extremes, back-to-back and long stall");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("vertex_model_transform_tb: done, clean");
		else
			$display("vertex_model_transform_tb: done, errors");
		$finish;
	end
endmodule
